@@ src/mqtr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqtr_pkg - shared types and constants of the matrix quarter-turn rotator
// Sizes, status codes, register indexes and the control struct that runs
// from the frame sequencer to the top level.
// ----------------------------------------------------------------------------
package mqtr_pkg;

  localparam int unsigned MAX_ROWS     = 256;
  localparam int unsigned MAX_COLS     = 256;
  localparam int unsigned ELEMENT_BITS = 32;

  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_STORED    = 2'd1,
    ST_TOO_EARLY = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_NUM_ROWS      = 2'd0,
    CFG_NUM_COLS      = 2'd1,
    CFG_QUARTER_TURNS = 2'd2,
    CFG_TURN_LEFT     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_e;

  // effective geometry after clamping and direction folding
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] orows;
    logic [DIM_W-1:0] ocols;
    turn_e            turn;
  } geom_t;

  // per-beat decision of the sequencer
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    status_e           status;
    logic              row_end;
    logic              frame_end;
  } ctl_t;

endpackage : mqtr_pkg
`default_nettype wire

@@ src/mqtr_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mqtr_seq - load counter, output position and store addressing
// Decides status and marks of each beat and steps the frame counters.
// ----------------------------------------------------------------------------
module mqtr_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire mqtr_pkg::op_e   op_i,
  input  wire mqtr_pkg::geom_t geom_i,
  output mqtr_pkg::ctl_t       ctl_o
);
  import mqtr_pkg::*;

  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]  row_idx_q, row_idx_d;
  logic [IDX_W-1:0]  col_idx_q, col_idx_d;

  logic [CNT_W-1:0]  total;
  logic              complete;
  logic [IDX_W-1:0]  r, c, sr, sc;
  logic [CNT_W-1:0]  prod;
  logic [ADDR_W-1:0] fetch_addr;
  logic              col_last, row_last;

  assign total    = CNT_W'(geom_i.rows) * CNT_W'(geom_i.cols);
  assign complete = (load_cnt_q >= total);

  // clip a stale position to the last row or column
  assign r = ({1'b0, row_idx_q} < geom_i.orows) ? row_idx_q : IDX_W'(geom_i.orows - 1'b1);
  assign c = ({1'b0, col_idx_q} < geom_i.ocols) ? col_idx_q : IDX_W'(geom_i.ocols - 1'b1);

  always_comb begin
    unique case (geom_i.turn)
      TURN_0: begin
        sr = r;
        sc = c;
      end
      TURN_90: begin
        sr = IDX_W'(geom_i.rows - DIM_W'(1) - {1'b0, c});
        sc = r;
      end
      TURN_180: begin
        sr = IDX_W'(geom_i.rows - DIM_W'(1) - {1'b0, r});
        sc = IDX_W'(geom_i.cols - DIM_W'(1) - {1'b0, c});
      end
      TURN_270: begin
        sr = c;
        sc = IDX_W'(geom_i.cols - DIM_W'(1) - {1'b0, r});
      end
    endcase
  end

  assign prod       = CNT_W'(sr) * CNT_W'(geom_i.cols);
  assign fetch_addr = ADDR_W'(prod + CNT_W'(sc));
  assign col_last   = (({1'b0, c} + DIM_W'(1)) >= geom_i.ocols);
  assign row_last   = (({1'b0, r} + DIM_W'(1)) >= geom_i.orows);

  always_comb begin
    ctl_o      = '0;
    load_cnt_d = load_cnt_q;
    row_idx_d  = row_idx_q;
    col_idx_d  = col_idx_q;
    ctl_o.status = ST_STORED;
    if (accept_i) begin
      if (op_i == OP_LOAD) begin
        if (complete) begin
          ctl_o.status = ST_OVERFLOW;
        end else begin
          ctl_o.status = ST_STORED;
          ctl_o.we     = 1'b1;
          ctl_o.addr   = ADDR_W'(load_cnt_q);
          load_cnt_d   = load_cnt_q + CNT_W'(1);
        end
      end else if (!complete) begin
        ctl_o.status = ST_TOO_EARLY;
      end else begin
        ctl_o.status = ST_DELIVERED;
        ctl_o.re     = 1'b1;
        ctl_o.addr   = fetch_addr;
        if (col_last) begin
          ctl_o.row_end = 1'b1;
          if (row_last) begin
            ctl_o.frame_end = 1'b1;
            load_cnt_d      = '0;
            row_idx_d       = '0;
            col_idx_d       = '0;
          end else begin
            row_idx_d = r + IDX_W'(1);
            col_idx_d = '0;
          end
        end else begin
          row_idx_d = r;
          col_idx_d = c + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      row_idx_q  <= '0;
      col_idx_q  <= '0;
    end else begin
      load_cnt_q <= load_cnt_d;
      row_idx_q  <= row_idx_d;
      col_idx_q  <= col_idx_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CNT_W'(STORE_DEPTH))
    else $error("load count beyond store depth");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.frame_end |=> (load_cnt_q == '0) && (row_idx_q == '0) && (col_idx_q == '0))
    else $error("frame end did not return to loading");

  a_one_port_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.we && ctl_o.re))
    else $error("store read and write in one beat");

  a_early_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (ctl_o.status == ST_TOO_EARLY) |=> $stable(load_cnt_q))
    else $error("early fetch changed the load count");

endmodule : mqtr_seq
`default_nettype wire

@@ src/matrix_quarter_turn_rotator_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_quarter_turn_rotator_core - matrix rotation by quarter turns
// Loads a matrix in row-major order and streams it back rotated.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken at a rising edge with start_i high and
//   busy_o low. busy_o stays low, so one beat can be issued every cycle.
//   operation_i = load stores element_in_i at the next row-major position;
//   operation_i = fetch reads the next element of the rotated matrix.
//   Result channel: valid_o marks each result for exactly one cycle, in the
//   cycle after its command beat (one beat per cycle, set by the single
//   port of the frame store). The receiver cannot stall, so results must
//   be taken as they appear.
//   Configuration: cfg_we_i writes cfg_data_i into the register selected by
//   cfg_idx_i (rows, cols, quarter turns, direction). Write only while idle.
//   Status: delivered, stored, fetch too early, or load overflow. After the
//   element that ends the frame the block returns to loading.
//   Reset: counters clear, size returns to 1 x 1 with no rotation; the frame
//   store keeps whatever it held and is valid only once loaded.
// ----------------------------------------------------------------------------
module matrix_quarter_turn_rotator_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic                                  operation_i,
  input  wire logic signed [mqtr_pkg::ELEMENT_BITS-1:0] element_in_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mqtr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [mqtr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                       valid_o,
  output logic signed [mqtr_pkg::ELEMENT_BITS-1:0]   element_out_o,
  output logic                                       row_end_o,
  output logic                                       frame_end_o,
  output logic [mqtr_pkg::DIM_W-1:0]                 out_rows_o,
  output logic [mqtr_pkg::DIM_W-1:0]                 out_cols_o,
  output logic [1:0]                                 status_o
);
  import mqtr_pkg::*;

  // configuration registers
  logic [DIM_W-1:0] num_rows_q, num_cols_q;
  logic [1:0]       turns_q;
  logic             left_q;

  // geometry and per-beat control
  logic [DIM_W-1:0] rows_eff, cols_eff;
  turn_e            turn;
  geom_t            geom;
  ctl_t             ctl;
  logic             accept;

  // frame store and result registers
  logic [ELEMENT_BITS-1:0] store_mem [STORE_DEPTH];
  logic [ELEMENT_BITS-1:0] rd_q;
  logic                    valid_q;
  status_e                 status_q;
  logic                    row_end_q, frame_end_q;
  logic [DIM_W-1:0]        orows_q, ocols_q;

  // every beat completes in one pass, so never hold off a command
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= DIM_W'(1);
      num_cols_q <= DIM_W'(1);
      turns_q    <= '0;
      left_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_NUM_ROWS:      num_rows_q <= cfg_data_i;
        CFG_NUM_COLS:      num_cols_q <= cfg_data_i;
        CFG_QUARTER_TURNS: turns_q    <= cfg_data_i[1:0];
        CFG_TURN_LEFT:     left_q     <= cfg_data_i[0];
      endcase
    end
  end

  // clamp sizes: zero acts as one, oversize acts as the maximum
  assign rows_eff = (num_rows_q == '0) ? DIM_W'(1) :
                    (num_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : num_rows_q;
  assign cols_eff = (num_cols_q == '0) ? DIM_W'(1) :
                    (num_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : num_cols_q;

  // fold a left turn into the equivalent right turn
  assign turn = turn_e'(left_q ? 2'(~turns_q + 2'd1) : turns_q);

  assign geom.rows  = rows_eff;
  assign geom.cols  = cols_eff;
  assign geom.turn  = turn;
  assign geom.orows = turn[0] ? cols_eff : rows_eff;
  assign geom.ocols = turn[0] ? rows_eff : cols_eff;

  mqtr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_e'(operation_i)),
    .geom_i   (geom),
    .ctl_o    (ctl)
  );

  // single-port frame store: write a loaded beat, read a fetched one
  always_ff @(posedge clk_i) begin
    if (ctl.we) begin
      store_mem[ctl.addr] <= element_in_i;
    end
    if (ctl.re) begin
      rd_q <= store_mem[ctl.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  // result payload: capture with the beat, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= ctl.status;
      row_end_q   <= ctl.row_end;
      frame_end_q <= ctl.frame_end;
      orows_q     <= geom.orows;
      ocols_q     <= geom.ocols;
    end
  end

  assign valid_o       = valid_q;
  assign element_out_o = (status_q == ST_DELIVERED) ? rd_q : '0;
  assign row_end_o     = row_end_q;
  assign frame_end_o   = frame_end_q;
  assign out_rows_o    = orows_q;
  assign out_cols_o    = ocols_q;
  assign status_o      = status_q;

  a_one_result_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted beat produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !valid_o)
    else $error("result without a command beat");

  a_frame_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  a_marks_only_on_delivery: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_q != ST_DELIVERED) |-> !row_end_o && (element_out_o == '0))
    else $error("marks or data on a non-delivering result");

endmodule : matrix_quarter_turn_rotator_core
`default_nettype wire
